// ===== hdl/qea_pkg.sv =====
// Shared widths, constants and helpers for the quaternion to Euler angle core.
// Used by every module of the core; depends on nothing else.
`default_nettype none

package qea_pkg;

    // Input component width, Q1.14.
    localparam int QW = 16;
    // Working width of the sums, Q28 with headroom for out-of-range inputs.
    localparam int OP_W = 36;
    // Radicand of the pitch cosine, 2^56 - s^2, and its square root.
    localparam int RAD_W = 57;
    localparam int ROOT_W = 29;
    // CORDIC datapath width and angle accumulator width (degree * 2^20).
    localparam int CW = 44;
    localparam int ANG_W = 31;
    localparam int ACC_FRAC = 20;
    localparam int CORDIC_ITERS = 24;
    // Operands are doubled until the larger magnitude reaches 2^NORM_EXP.
    localparam int NORM_EXP = 40;
    localparam int NORM_STEPS = 6;
    localparam int NORM_LAT = NORM_STEPS + 1;
    localparam int FRONT_LAT = 3;

    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int Q28_INT = 268435456;

    localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(90 * (1 << ACC_FRAC));
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * (1 << ACC_FRAC));

    // atan(2^-i) in degree * 2^20, rounded to nearest.
    localparam int ATAN_TAB [CORDIC_ITERS] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    // Clamp an accumulated angle to +/-lim, force zero for a null vector, then
    // round to the output unit with half an LSB added and a floor shift.
    function automatic logic signed [ANG_W+1:0] out_units(
        input logic signed [ANG_W-1:0] z,
        input logic                    zero,
        input logic signed [ANG_W-1:0] lim,
        input int                      sh
    );
        logic signed [ANG_W+1:0] zc;
        logic signed [ANG_W+1:0] half;
        if (zero)
            zc = '0;
        else if (z > lim)
            zc = (ANG_W+2)'(lim);
        else if (z < -lim)
            zc = -((ANG_W+2)'(lim));
        else
            zc = (ANG_W+2)'(z);
        half = (ANG_W+2)'(1) <<< (sh - 1);
        return (zc + half) >>> sh;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/qea_front.sv =====
// Front end: component products, Q28 sums and the pitch radicand.
// Three register stages; depends on qea_pkg.
`default_nettype none

module qea_front (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic signed [qea_pkg::QW-1:0]   quat_x,
    input  wire logic signed [qea_pkg::QW-1:0]   quat_y,
    input  wire logic signed [qea_pkg::QW-1:0]   quat_z,
    input  wire logic signed [qea_pkg::QW-1:0]   quat_w,
    output logic signed [qea_pkg::OP_W-1:0]      s_out,
    output logic signed [qea_pkg::OP_W-1:0]      sy_out,
    output logic signed [qea_pkg::OP_W-1:0]      cy_out,
    output logic signed [qea_pkg::OP_W-1:0]      sr_out,
    output logic signed [qea_pkg::OP_W-1:0]      cr_out,
    output logic [qea_pkg::RAD_W-1:0]            rad_out,
    output logic                                 big_out
);
    import qea_pkg::*;

    localparam int PW = 2 * QW;

    // Stage 1: the nine products.
    logic signed [PW-1:0] wy_reg, zx_reg, wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            zz_reg <= quat_z * quat_z;
        end
    end

    // Stage 2: doubled sums in Q28, and the magnitude of the sine term.
    logic signed [OP_W-1:0] s_next, sy_next, cy_next, sr_next, cr_next, s_abs;
    logic signed [OP_W-1:0] s2_reg, sy2_reg, cy2_reg, sr2_reg, cr2_reg;
    logic [ROOT_W-2:0]      mag_reg;
    logic                   big2_reg;
    localparam logic signed [OP_W-1:0] ONE_Q28 = OP_W'(Q28_INT);

    always_comb
    begin
        s_next  = (OP_W'(wy_reg) - OP_W'(zx_reg)) <<< 1;
        sy_next = (OP_W'(wx_reg) + OP_W'(yz_reg)) <<< 1;
        cy_next = ONE_Q28 - ((OP_W'(xx_reg) + OP_W'(yy_reg)) <<< 1);
        sr_next = (OP_W'(wz_reg) + OP_W'(xy_reg)) <<< 1;
        cr_next = ONE_Q28 - ((OP_W'(yy_reg) + OP_W'(zz_reg)) <<< 1);
        s_abs   = (s_next < 0) ? -s_next : s_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg   <= s_next;
            sy2_reg  <= sy_next;
            cy2_reg  <= cy_next;
            sr2_reg  <= sr_next;
            cr2_reg  <= cr_next;
            mag_reg  <= s_abs[ROOT_W-2:0];
            big2_reg <= (s_abs >= ONE_Q28);
        end
    end

    // Stage 3: radicand 2^56 - s^2 for the pitch cosine.
    logic [2*(ROOT_W-1)-1:0] sq;
    logic [RAD_W-1:0]        rad_next;

    always_comb
    begin
        sq       = mag_reg * mag_reg;
        rad_next = (RAD_W'(1) << (RAD_W - 1)) - RAD_W'(sq);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_out   <= s2_reg;
            sy_out  <= sy2_reg;
            cy_out  <= cy2_reg;
            sr_out  <= sr2_reg;
            cr_out  <= cr2_reg;
            rad_out <= rad_next;
            big_out <= big2_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qea_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side word
// that travels alongside. Depends on qea_pkg.
`default_nettype none

module qea_isqrt #(
    parameter int PASS_W = 1
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [qea_pkg::RAD_W-1:0]     rad,
    input  wire logic [PASS_W-1:0]             pass_in,
    output logic [qea_pkg::ROOT_W-1:0]         root,
    output logic [PASS_W-1:0]                  pass_out
);
    import qea_pkg::*;

    localparam int TW = RAD_W + 1;

    logic [RAD_W-1:0]  rem_reg  [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg [1:ROOT_W];
    logic [PASS_W-1:0] pass_reg [1:ROOT_W];

    // Each stage tries the next lower root bit against the running remainder.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [PASS_W-1:0] pass_stage;
        logic [TW-1:0]     trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign rem_in     = rad;
            assign root_in    = '0;
            assign pass_stage = pass_in;
        end
        else
        begin : g_rest
            assign rem_in     = rem_reg[k];
            assign root_in    = root_reg[k];
            assign pass_stage = pass_reg[k];
        end

        assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
        assign take  = ({1'b0, rem_in} >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? RAD_W'({1'b0, rem_in} - trial) : rem_in;
                root_reg[k+1] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
                pass_reg[k+1] <= pass_stage;
            end
        end
    end

    assign root     = root_reg[ROOT_W];
    assign pass_out = pass_reg[ROOT_W];

endmodule

`default_nettype wire

// ===== hdl/qea_norm.sv =====
// Operand preparation for one CORDIC lane: half-plane fold and left
// normalisation by 32, 16, 8, 4, 2 and 1 places. Depends on qea_pkg.
`default_nettype none

module qea_norm (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [qea_pkg::OP_W-1:0]   y_in,
    input  wire logic signed [qea_pkg::OP_W-1:0]   x_in,
    output logic signed [qea_pkg::CW-1:0]          y_out,
    output logic signed [qea_pkg::CW-1:0]          x_out,
    output logic signed [qea_pkg::ANG_W-1:0]       z_out,
    output logic                                   zero_out
);
    import qea_pkg::*;

    logic signed [CW-1:0]    x_reg [0:NORM_STEPS];
    logic signed [CW-1:0]    y_reg [0:NORM_STEPS];
    logic signed [ANG_W-1:0] z_reg [0:NORM_STEPS];
    logic                    zero_reg [0:NORM_STEPS];

    // Fold a negative x into the right half plane, starting at +/-180 degrees.
    logic signed [CW-1:0] x_ext, y_ext;
    logic                 neg;

    always_comb
    begin
        x_ext = CW'(x_in);
        y_ext = CW'(y_in);
        neg   = (x_in < 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= neg ? -x_ext : x_ext;
            y_reg[0]    <= neg ? -y_ext : y_ext;
            z_reg[0]    <= neg ? ((y_in >= 0) ? DEG180 : -DEG180) : '0;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    // Binary search on the shift: move by K places while the larger
    // magnitude stays below 2^(NORM_EXP+1).
    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_shift
        localparam int K = 1 << (NORM_STEPS - 1 - j);
        localparam logic signed [CW-1:0] LIM = CW'(1) << (NORM_EXP + 1 - K);
        logic fits;

        assign fits = (x_reg[j] < LIM) && (y_reg[j] < LIM) && (y_reg[j] > -LIM);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[j+1]    <= fits ? (x_reg[j] <<< K) : x_reg[j];
                y_reg[j+1]    <= fits ? (y_reg[j] <<< K) : y_reg[j];
                z_reg[j+1]    <= z_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end
    end

    assign x_out    = x_reg[NORM_STEPS];
    assign y_out    = y_reg[NORM_STEPS];
    assign z_out    = z_reg[NORM_STEPS];
    assign zero_out = zero_reg[NORM_STEPS];

endmodule

`default_nettype wire

// ===== hdl/qea_cordic.sv =====
// Vectoring CORDIC lane, one micro-rotation per register stage.
// Depends on qea_pkg for widths and the arctangent table.
`default_nettype none

module qea_cordic (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [qea_pkg::CW-1:0]     y_in,
    input  wire logic signed [qea_pkg::CW-1:0]     x_in,
    input  wire logic signed [qea_pkg::ANG_W-1:0]  z_in,
    input  wire logic                              zero_in,
    output logic signed [qea_pkg::ANG_W-1:0]       z_out,
    output logic                                   zero_out
);
    import qea_pkg::*;

    logic signed [CW-1:0]    x_reg [1:CORDIC_ITERS];
    logic signed [CW-1:0]    y_reg [1:CORDIC_ITERS];
    logic signed [ANG_W-1:0] z_reg [1:CORDIC_ITERS];
    logic                    zero_reg [1:CORDIC_ITERS];

    // Rotate towards y = 0, accumulating the angle from the table.
    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        localparam logic signed [ANG_W-1:0] STEP = ANG_W'(ATAN_TAB[i]);
        logic signed [CW-1:0]    xs, ys, xi, yi;
        logic signed [ANG_W-1:0] zi;
        logic                    zi_zero;

        if (i == 0)
        begin : g_first
            assign xi      = x_in;
            assign yi      = y_in;
            assign zi      = z_in;
            assign zi_zero = zero_in;
        end
        else
        begin : g_rest
            assign xi      = x_reg[i];
            assign yi      = y_reg[i];
            assign zi      = z_reg[i];
            assign zi_zero = zero_reg[i];
        end

        assign xs = xi >>> i;
        assign ys = yi >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yi >= 0)
                begin
                    x_reg[i+1] <= xi + ys;
                    y_reg[i+1] <= yi - xs;
                    z_reg[i+1] <= zi + STEP;
                end
                else
                begin
                    x_reg[i+1] <= xi - ys;
                    y_reg[i+1] <= yi + xs;
                    z_reg[i+1] <= zi - STEP;
                end
                zero_reg[i+1] <= zi_zero;
            end
        end
    end

    assign z_out    = z_reg[CORDIC_ITERS];
    assign zero_out = zero_reg[CORDIC_ITERS];

endmodule

`default_nettype wire

// ===== hdl/quaternion_to_euler_angles_core.sv =====
// Top level of the quaternion to Euler angle core: pipeline control, lanes
// and output rounding. Depends on qea_pkg and all qea_* modules.
`default_nettype none

// One Q1.14 quaternion word goes in per clock and one word of angles comes
// out per clock while the pipeline advances. The depth from acceptance to
// the output register is set by the pitch path: three front stages for
// products, sums and the squared sine, 29 square-root stages (one root bit
// each), 7 normalisation stages and 24 CORDIC stages, then the rounding
// register. Yaw and roll ride alongside on their own lanes. The whole pipeline
// advances whenever the output register is empty or being read, so a held
// output stalls every stage in place and in_ready falls in the same cycle.
// Angles are in units of 1/2^ANGLE_FRAC_BITS degree; pitch_clamped marks words
// whose asin argument reached magnitude one, with pitch forced to +/-90 degrees.
module quaternion_to_euler_angles_core #(
    parameter int ANGLE_FRAC_BITS = qea_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [qea_pkg::QW-1:0]   quat_x,
    input  wire logic signed [qea_pkg::QW-1:0]   quat_y,
    input  wire logic signed [qea_pkg::QW-1:0]   quat_z,
    input  wire logic signed [qea_pkg::QW-1:0]   quat_w,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [13:0]                   pitch_angle,
    output logic signed [14:0]                   yaw_angle,
    output logic signed [14:0]                   roll_angle,
    output logic                                 pitch_clamped
);
    import qea_pkg::*;

    localparam int LAT = FRONT_LAT + ROOT_W + NORM_LAT + CORDIC_ITERS + 1;
    localparam int SIDE_LAT = NORM_LAT + CORDIC_ITERS;
    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int PASS_W = 5 * OP_W + 1;
    localparam logic signed [ANG_W+1:0] P90 = (ANG_W+2)'(90) <<< ANGLE_FRAC_BITS;

    // Pipeline advance and valid line.
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // Front end.
    logic signed [OP_W-1:0] s_f, sy_f, cy_f, sr_f, cr_f;
    logic [RAD_W-1:0]       rad_f;
    logic                   big_f;

    qea_front u_front (
        .clk     (clk),
        .en      (en),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .quat_w  (quat_w),
        .s_out   (s_f),
        .sy_out  (sy_f),
        .cy_out  (cy_f),
        .sr_out  (sr_f),
        .cr_out  (cr_f),
        .rad_out (rad_f),
        .big_out (big_f)
    );

    // Pitch cosine by square root; the other operands travel with it.
    logic [ROOT_W-1:0]      root_q;
    logic [PASS_W-1:0]      pass_q;
    logic signed [OP_W-1:0] s_q, sy_q, cy_q, sr_q, cr_q;
    logic                   big_q;

    qea_isqrt #(
        .PASS_W (PASS_W)
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .rad      (rad_f),
        .pass_in  ({s_f, sy_f, cy_f, sr_f, cr_f, big_f}),
        .root     (root_q),
        .pass_out (pass_q)
    );

    assign {s_q, sy_q, cy_q, sr_q, cr_q, big_q} = pass_q;

    // Clamp flag and sine sign wait for the CORDIC lanes.
    logic [SIDE_LAT-1:0] clamp_dly_reg, neg_dly_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_dly_reg <= {clamp_dly_reg[SIDE_LAT-2:0], big_q};
            neg_dly_reg   <= {neg_dly_reg[SIDE_LAT-2:0], (s_q < 0)};
        end
    end

    // Three angle lanes: pitch, yaw, roll.
    logic signed [OP_W-1:0]  lane_y [3];
    logic signed [OP_W-1:0]  lane_x [3];
    logic signed [ANG_W-1:0] lane_z [3];
    logic                    lane_zero [3];

    assign lane_y[0] = s_q;
    assign lane_x[0] = OP_W'(root_q);
    assign lane_y[1] = sy_q;
    assign lane_x[1] = cy_q;
    assign lane_y[2] = sr_q;
    assign lane_x[2] = cr_q;

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic signed [CW-1:0]    ny, nx;
        logic signed [ANG_W-1:0] nz;
        logic                    nzero;

        qea_norm u_norm (
            .clk      (clk),
            .en       (en),
            .y_in     (lane_y[l]),
            .x_in     (lane_x[l]),
            .y_out    (ny),
            .x_out    (nx),
            .z_out    (nz),
            .zero_out (nzero)
        );

        qea_cordic u_cordic (
            .clk      (clk),
            .en       (en),
            .y_in     (ny),
            .x_in     (nx),
            .z_in     (nz),
            .zero_in  (nzero),
            .z_out    (lane_z[l]),
            .zero_out (lane_zero[l])
        );
    end

    // Output register: clamp, round and, for a saturated sine, force +/-90.
    logic signed [ANG_W+1:0] pitch_full, yaw_full, roll_full;
    logic signed [13:0]      pitch_next;

    always_comb
    begin
        pitch_full = out_units(lane_z[0], lane_zero[0], DEG90, SH);
        yaw_full   = out_units(lane_z[1], lane_zero[1], DEG180, SH);
        roll_full  = out_units(lane_z[2], lane_zero[2], DEG180, SH);
        if (clamp_dly_reg[SIDE_LAT-1])
            pitch_next = neg_dly_reg[SIDE_LAT-1] ? 14'(-P90) : 14'(P90);
        else
            pitch_next = 14'(pitch_full);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_angle   <= pitch_next;
            yaw_angle     <= 15'(yaw_full);
            roll_angle    <= 15'(roll_full);
            pitch_clamped <= clamp_dly_reg[SIDE_LAT-1];
        end
    end

    // Checks on the datapath results and on the stall handshake.
    localparam logic [13:0] P90_W  = 14'(P90);
    localparam logic [13:0] P90N_W = 14'(-P90);
    localparam int YLIM = 180 * (1 << ANGLE_FRAC_BITS);

    a_clamp_value : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pitch_clamped |-> (pitch_angle == P90_W) || (pitch_angle == P90N_W))
        else $error("clamped pitch is not +/-90 degrees");

    a_yaw_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ANGLE_FRAC_BITS <= 6) |->
            ($signed(yaw_angle) <= YLIM) && ($signed(yaw_angle) >= -YLIM))
        else $error("yaw outside +/-180 degrees");

    a_roll_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ANGLE_FRAC_BITS <= 6) |->
            ($signed(roll_angle) <= YLIM) && ($signed(roll_angle) >= -YLIM))
        else $error("roll outside +/-180 degrees");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> out_valid)
        else $error("input stalled while the output register was empty");

endmodule

`default_nettype wire
